// File: hw/rtl/ksel_pkg.sv
package ksel_pkg;

  localparam int unsigned KEY_W    = 32;
  localparam int unsigned WANTED_W = 5;
  localparam logic [WANTED_W-1:0] WANTED_RESET = 5'd5;

  // Operation broadcast to all cells of the chain in the same cycle.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT,
    CELL_CLEAR
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [KEY_W-1:0] key;
  } cell_ctrl_t;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } sel_state_t;

endpackage

// File: hw/rtl/ksel_cell.sv
module ksel_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  ksel_pkg::cell_ctrl_t       ctrl,
  input  logic [ksel_pkg::KEY_W-1:0] left_key,
  input  logic                       left_valid,
  input  logic                       left_le,
  input  logic [ksel_pkg::KEY_W-1:0] right_key,
  input  logic                       right_valid,
  output logic [ksel_pkg::KEY_W-1:0] key,
  output logic                       valid,
  output logic                       le
);

  logic [ksel_pkg::KEY_W-1:0] key_next;
  logic                       valid_next;

  // True when this entry stays ahead of the broadcast key (equal keys stay ahead).
  assign le = valid && (key <= ctrl.key);

  always_comb begin
    key_next   = key;
    valid_next = valid;
    case (ctrl.op)
      ksel_pkg::CELL_INSERT: begin
        if (!le) begin
          if (left_le) begin
            key_next   = ctrl.key;
            valid_next = 1'b1;
          end else begin
            // Take the left neighbor's entry; cells past the end of the kept entries stay empty.
            key_next   = left_key;
            valid_next = left_valid;
          end
        end
      end
      ksel_pkg::CELL_SHIFT: begin
        key_next   = right_key;
        valid_next = right_valid;
      end
      ksel_pkg::CELL_CLEAR: begin
        valid_next = 1'b0;
      end
      default: begin
        key_next   = key;
        valid_next = valid;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    key <= key_next;
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

endmodule

// File: hw/rtl/k_smallest_selector.sv
// Keeps the smallest MAX_KEEP price keys of a set in a sorted chain of cells and, on the
// last item of the set, streams out the smallest min(wanted, kept) keys in ascending order
// with tlast on the final one. Keys are 32-bit unsigned values whose unsigned order is the
// price order. Prices are taken one per cycle while loading: every cell compares the new
// key against its own entry in the same cycle and either keeps its entry, takes the new
// key, or takes its left neighbor's entry. After the item marked tlast, input is held off
// while the results drain out of the head of the chain, one per output transfer, and the
// chain is then cleared before loading starts again. Keys beyond MAX_KEEP that are not
// smaller than the largest kept key are dropped. Equal keys are kept as separate entries,
// the newer one after the older. The wanted register may be written only while the block
// is idle.
module k_smallest_selector #(
  parameter int unsigned MAX_KEEP = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // Input stream.
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [ksel_pkg::KEY_W-1:0]    s_tdata,   // [31:0] price_key
  input  logic                          s_tlast,   // set_end
  // Result stream.
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [ksel_pkg::KEY_W-1:0]    m_tdata,   // [31:0] out_price_key
  output logic                          m_tlast,   // out_last
  // Configuration: the wanted register.
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ksel_pkg::WANTED_W-1:0] cfg_data
);

  localparam int unsigned CNT_W = $clog2(MAX_KEEP + 1);
  localparam int unsigned CMP_W = (CNT_W > ksel_pkg::WANTED_W) ? CNT_W : ksel_pkg::WANTED_W;

  ksel_pkg::sel_state_t state, state_next;
  ksel_pkg::cell_ctrl_t ctrl;

  logic [ksel_pkg::WANTED_W-1:0] wanted;
  logic [CNT_W-1:0]              kept_count;
  logic [CNT_W-1:0]              count_ins;
  logic [CNT_W-1:0]              remaining;
  logic [CMP_W-1:0]              wanted_ext;
  logic [CMP_W-1:0]              count_ext;

  logic [ksel_pkg::KEY_W-1:0] cell_key   [MAX_KEEP];
  logic                       cell_valid [MAX_KEEP];
  logic                       cell_le    [MAX_KEEP];

  logic in_xfer;
  logic out_xfer;

  assign cfg_ready = 1'b1;
  assign in_xfer   = s_tvalid && s_tready;
  assign out_xfer  = m_tvalid && m_tready;

  // Count after the incoming key has gone in; the store saturates at MAX_KEEP.
  assign count_ins  = (kept_count < CNT_W'(MAX_KEEP)) ? kept_count + 1'b1 : kept_count;
  assign wanted_ext = CMP_W'(wanted);
  assign count_ext  = CMP_W'(count_ins);

  // The head of the chain is the output register.
  assign m_tdata = cell_key[0];
  assign m_tlast = (remaining == CNT_W'(1));

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ksel_pkg::ST_LOAD: begin
        if (in_xfer && s_tlast) begin
          state_next = ksel_pkg::ST_DRAIN;
        end
      end
      ksel_pkg::ST_DRAIN: begin
        if (remaining == '0) begin
          state_next = ksel_pkg::ST_LOAD;
        end
      end
      default: begin
        state_next = ksel_pkg::ST_LOAD;
      end
    endcase
  end

  // Outputs and the command broadcast to the cells.
  always_comb begin
    s_tready = 1'b0;
    m_tvalid = 1'b0;
    ctrl.op  = ksel_pkg::CELL_HOLD;
    ctrl.key = s_tdata;
    unique case (state)
      ksel_pkg::ST_LOAD: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          ctrl.op = ksel_pkg::CELL_INSERT;
        end
      end
      ksel_pkg::ST_DRAIN: begin
        if (remaining == '0) begin
          ctrl.op = ksel_pkg::CELL_CLEAR;
        end else begin
          m_tvalid = 1'b1;
          if (m_tready) begin
            ctrl.op = ksel_pkg::CELL_SHIFT;
          end
        end
      end
      default: begin
        ctrl.op = ksel_pkg::CELL_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ksel_pkg::ST_LOAD;
      wanted     <= ksel_pkg::WANTED_RESET;
      kept_count <= '0;
      remaining  <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        wanted <= cfg_data;
      end
      if (in_xfer) begin
        kept_count <= count_ins;
        if (s_tlast) begin
          // Number of results for this set: the smaller of wanted and the kept count.
          remaining <= (wanted_ext < count_ext) ? CNT_W'(wanted) : count_ins;
        end
      end else if (state == ksel_pkg::ST_DRAIN && remaining == '0) begin
        kept_count <= '0;
      end else if (out_xfer) begin
        remaining <= remaining - 1'b1;
      end
    end
  end

  // The chain: cell 0 holds the smallest key. Inserts move entries toward the tail,
  // draining moves them toward the head.
  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
    logic [ksel_pkg::KEY_W-1:0] left_key;
    logic                       left_valid;
    logic                       left_le;
    logic [ksel_pkg::KEY_W-1:0] right_key;
    logic                       right_valid;

    if (i == 0) begin : g_head
      assign left_key   = '0;
      assign left_valid = 1'b1;
      assign left_le    = 1'b1;
    end else begin : g_body
      assign left_key   = cell_key[i-1];
      assign left_valid = cell_valid[i-1];
      assign left_le    = cell_le[i-1];
    end

    if (i == MAX_KEEP - 1) begin : g_tail
      assign right_key   = '0;
      assign right_valid = 1'b0;
    end else begin : g_inner
      assign right_key   = cell_key[i+1];
      assign right_valid = cell_valid[i+1];
    end

    ksel_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .left_key    (left_key),
      .left_valid  (left_valid),
      .left_le     (left_le),
      .right_key   (right_key),
      .right_valid (right_valid),
      .key         (cell_key[i]),
      .valid       (cell_valid[i]),
      .le          (cell_le[i])
    );
  end

endmodule

// File: tb/k_smallest_selector_test.sv
`timescale 1ns / 1ps

module k_smallest_selector_test;

  localparam int unsigned KEY_W        = ksel_pkg::KEY_W;
  localparam int unsigned WANTED_W     = ksel_pkg::WANTED_W;
  localparam int unsigned MAX_KEEP     = 16;
  localparam int unsigned RANDOM_ITEMS = 150;
  // Cycles allowed after the last result before the chain counts as idle: the block
  // clears the chain after each drained set, even an empty one.
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned TAIL_CYCLES   = 32;
  // Long receiver hold-off, long enough to stall the input side during a drain.
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned CYCLE_LIMIT   = 400000;

  // Directed table: a row either writes the wanted register or offers one price.
  typedef enum logic {
    ROW_WANTED,
    ROW_PRICE
  } row_kind_t;

  // How the expectation of a price row is formed.
  typedef enum logic [1:0] {
    PIN_MODEL,   // whatever the predictor works out
    PIN_NONE,    // typed in: the row produces nothing
    PIN_ONE      // typed in: exactly one result, pin_key, flagged as the tail
  } pin_t;

  typedef struct packed {
    row_kind_t        kind;
    logic [KEY_W-1:0] value;
    logic             set_end;
    pin_t             pin;
    logic [KEY_W-1:0] pin_key;
  } stim_row_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             tail;
  } cheap_price_t;

  // Shapes of random price content.
  typedef enum logic [1:0] {
    MIX_WIDE,
    MIX_TIES,
    MIX_TOP,
    MIX_BLEND
  } price_mix_t;

  // Receiver behavior, redrawn at random whenever the current mode runs out.
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_PULSE
  } rx_mode_t;

  // Every block input starts at a known value.
  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [KEY_W-1:0]    s_tdata   = '0;   // [31:0] price_key
  logic                s_tlast   = 1'b0; // set_end
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [KEY_W-1:0]    m_tdata;          // [31:0] out_price_key
  logic                m_tlast;          // out_last
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [WANTED_W-1:0] cfg_data  = '0;

  k_smallest_selector #(
    .MAX_KEEP(MAX_KEEP)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #4 clk = ~clk;

  // Predictor state: the kept keys of the open set, sorted ascending, and the
  // register value as the block should hold it.
  logic [KEY_W-1:0]    kept_keys [MAX_KEEP];
  int unsigned         kept_total = 0;
  logic [WANTED_W-1:0] wanted_now = ksel_pkg::WANTED_RESET;

  // Cheapest prices still owed by the block, oldest first.
  cheap_price_t pending_cheapest[$];
  stim_row_t    stim_rows[$];

  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left  = 0;

  // The stimulus asks for one long receiver hold-off; the receiver times it itself.
  logic        stall_request = 1'b0;
  logic        stall_done    = 1'b0;
  int unsigned hold_left     = 0;
  rx_mode_t    rx_mode       = RX_OPEN;
  int unsigned rx_mode_left  = 0;
  int unsigned rx_phase      = 0;

  // Folds one accepted price into the predicted chain. A price that is not smaller
  // than every kept key of a full chain falls off the end; ties go behind the keys
  // already held. On the set's closing price the cheapest min(wanted, kept) keys
  // are owed in ascending order, and the chain starts over empty.
  function automatic void absorb_price(logic [KEY_W-1:0] key, logic set_end, bit record);
    int unsigned  slot;
    int unsigned  owed;
    int unsigned  j;
    cheap_price_t item;
    slot = 0;
    while (slot < kept_total && kept_keys[slot] <= key)
      slot++;
    if (slot < MAX_KEEP) begin
      j = (kept_total < MAX_KEEP) ? kept_total : MAX_KEEP - 1;
      while (j > slot) begin
        kept_keys[j] = kept_keys[j-1];
        j--;
      end
      kept_keys[slot] = key;
      if (kept_total < MAX_KEEP)
        kept_total++;
    end
    if (set_end) begin
      owed = (wanted_now < kept_total) ? wanted_now : kept_total;
      if (record) begin
        for (j = 0; j < owed; j++) begin
          item.key  = kept_keys[j];
          item.tail = (j + 1 == owed);
          pending_cheapest.push_back(item);
        end
      end
      kept_total = 0;
    end
  endfunction

  function automatic void add_row(row_kind_t kind, logic [KEY_W-1:0] value, logic set_end,
                                  pin_t pin, logic [KEY_W-1:0] pin_key);
    stim_row_t row;
    row.kind    = kind;
    row.value   = value;
    row.set_end = set_end;
    row.pin     = pin;
    row.pin_key = pin_key;
    stim_rows.push_back(row);
  endfunction

  function automatic logic [KEY_W-1:0] draw_price(price_mix_t mix);
    logic [KEY_W-1:0] key;
    case (mix)
      MIX_WIDE: key = $urandom();
      MIX_TIES: key = $urandom_range(0, 7);
      MIX_TOP:  key = 32'hFFFF_FFF8 | $urandom_range(0, 7);
      default: begin
        case ($urandom_range(0, 3))
          0:       key = $urandom_range(0, 3);
          1:       key = 32'hFFFF_FFFC | $urandom_range(0, 3);
          default: key = $urandom();
        endcase
      end
    endcase
    return key;
  endfunction

  // Offers one price and returns at the edge of its transfer. The sender works in
  // bursts: when one runs out, a random gap (sometimes none) precedes the next.
  task automatic offer_price(input logic [KEY_W-1:0] key, input logic set_end,
                             input bit record);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= key;
    s_tlast  <= set_end;
    @(posedge clk);
    while (!s_tready)
      @(posedge clk);
    absorb_price(key, set_end, record);
  endtask

  // Stops offering and waits until every owed price has come out and the chain
  // has had time to clear.
  task automatic settle_block();
    s_tvalid <= 1'b0;
    while (pending_cheapest.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_wanted(input logic [WANTED_W-1:0] value);
    settle_block();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    cfg_valid  <= 1'b0;
    wanted_now  = value;
  endtask

  // Receiver: one long hold-off on request, otherwise a changing stall pattern
  // that includes stretches where it never stalls.
  always @(posedge clk) begin
    if (stall_request && !stall_done) begin
      stall_done = 1'b1;
      hold_left  = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = rx_mode_t'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(8, 64);
      end
      rx_mode_left--;
      rx_phase++;
      case (rx_mode)
        RX_OPEN:   m_tready <= 1'b1;
        RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: m_tready <= ($urandom_range(0, 7) == 0);
        default:   m_tready <= (rx_phase % 3 == 0);
      endcase
    end
  end

  // Result checker: every transfer out of the block must match the oldest owed price.
  always @(posedge clk) begin : check_results
    cheap_price_t owed;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_cheapest.size() == 0) begin
        $display("%0t: unexpected result: expected nothing, actual key %h tlast %b",
                 $time, m_tdata, m_tlast);
        fail_count++;
      end else begin
        owed = pending_cheapest.pop_front();
        if (m_tdata !== owed.key) begin
          $display("%0t: key mismatch: expected %h, actual %h", $time, owed.key, m_tdata);
          fail_count++;
        end
        if (m_tlast !== owed.tail) begin
          $display("%0t: tlast mismatch: expected %b, actual %b", $time, owed.tail, m_tlast);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("k_smallest_selector regression: fail");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned         i;
    int unsigned         set_idx;
    int unsigned         set_total;
    int unsigned         set_len;
    int unsigned         random_items;
    logic [WANTED_W-1:0] phase_wanted;
    price_mix_t          mix;
    cheap_price_t        pinned;

    // Directed part. The register still holds its reset value, so a lone price
    // comes straight back as the tail of its set.
    add_row(ROW_PRICE, 32'h0000_0007, 1'b1, PIN_ONE, 32'h0000_0007);
    // Both key extremes and a tie: fewer kept keys than wanted.
    add_row(ROW_PRICE, 32'hFFFF_FFFF, 1'b0, PIN_MODEL, '0);
    add_row(ROW_PRICE, 32'h0000_0000, 1'b0, PIN_MODEL, '0);
    add_row(ROW_PRICE, 32'h8000_0000, 1'b0, PIN_MODEL, '0);
    add_row(ROW_PRICE, 32'h0000_0000, 1'b1, PIN_MODEL, '0);
    // Nothing wanted: the set is swallowed but still cleared.
    add_row(ROW_WANTED, 32'd0, 1'b0, PIN_MODEL, '0);
    add_row(ROW_PRICE, 32'h1234_5678, 1'b1, PIN_NONE, '0);
    // Wanted far above anything the chain can hold.
    add_row(ROW_WANTED, 32'd31, 1'b0, PIN_MODEL, '0);
    add_row(ROW_PRICE, 32'hFFFF_FFFF, 1'b1, PIN_ONE, 32'hFFFF_FFFF);
    // Full chain: sixteen falling keys, then a tie with the largest (dropped) and
    // a smaller one that pushes the largest out.
    add_row(ROW_WANTED, 32'd16, 1'b0, PIN_MODEL, '0);
    for (i = 0; i < MAX_KEEP; i++)
      add_row(ROW_PRICE, 32'h0100_0000 * (MAX_KEEP - i) + i, 1'b0, PIN_MODEL, '0);
    add_row(ROW_PRICE, 32'h1000_0000, 1'b0, PIN_MODEL, '0);
    add_row(ROW_PRICE, 32'h0000_0001, 1'b1, PIN_MODEL, '0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (stim_rows[r]) begin
      if (stim_rows[r].kind == ROW_WANTED) begin
        write_wanted(stim_rows[r].value[WANTED_W-1:0]);
      end else begin
        offer_price(stim_rows[r].value, stim_rows[r].set_end, stim_rows[r].pin == PIN_MODEL);
        if (stim_rows[r].pin == PIN_ONE) begin
          pinned.key  = stim_rows[r].pin_key;
          pinned.tail = 1'b1;
          pending_cheapest.push_back(pinned);
        end
      end
    end

    // Random part: phases of a few sets each, with a fresh register value per
    // phase. Most sets are short; some overrun the chain.
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 7))
        0:       phase_wanted = '0;
        1:       phase_wanted = WANTED_W'(MAX_KEEP);
        2:       phase_wanted = WANTED_W'($urandom_range(MAX_KEEP + 1, 31));
        default: phase_wanted = WANTED_W'($urandom_range(1, MAX_KEEP - 1));
      endcase
      write_wanted(phase_wanted);
      set_total = $urandom_range(2, 4);
      for (set_idx = 0; set_idx < set_total; set_idx++) begin
        set_len = ($urandom_range(0, 5) == 0) ? $urandom_range(MAX_KEEP + 1, 30)
                                              : $urandom_range(1, 8);
        mix = price_mix_t'($urandom_range(0, 3));
        for (i = 0; i < set_len; i++)
          offer_price(draw_price(mix), i + 1 == set_len, 1'b1);
        random_items += set_len;
        // The first drain with results, while more sets follow, gets the long
        // hold-off: the sender keeps offering into a stalled input.
        if (!stall_request && set_idx + 1 < set_total && pending_cheapest.size() > 0)
          stall_request <= 1'b1;
      end
    end

    settle_block();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("k_smallest_selector regression: pass");
    end else begin
      $display("k_smallest_selector regression: fail");
    end
    $finish;
  end

endmodule
